// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands. Expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset
`define SLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when ante holds, cons holds in the same cycle
`define SLE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/sle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants, command and status codes and the result bundle of the
// sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  // Default sizing
  localparam int unsigned SLE_CAPACITY  = 16;
  localparam int unsigned SLE_KEY_WIDTH = 32;

  // Fixed field widths on the ports
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PKEY_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RMIN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RMAX   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RVAL   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic                valid;
    logic [PKEY_W-1:0]   key;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                empty;
  } sle_res_t;

endpackage

// ===== src/sorted_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine
// Sorted key list with insert, remove-smallest, remove-largest and
// remove-by-value; keys live in a one-port-read, one-port-write store.
//
//   channel | dir | handshake               | fields
//   --------+-----+-------------------------+--------------------------------
//   in      | in  | in_valid_i / in_stall_o | command_i, key_in_i
//   out     | out | out_valid_o/out_stall_i | key_out_o, status_o,
//           |     |                         | entry_count_o, is_empty_o
//
// With n keys stored (n > 0) an item walks the store before its result reaches
// the output register: the walk reads one entry per cycle through the single
// read port. Insert may stop early at its slot, remove-largest reads only the
// last entry, and an empty list or an insert into a full list reads none.
// The input stalls until the result enters the output register, so the next
// item is accepted only after that; a full, stalled output register holds
// the sequencer. Reset empties the list; store contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
  parameter int unsigned CAPACITY  = sle_pkg::SLE_CAPACITY,
  parameter int unsigned KEY_WIDTH = sle_pkg::SLE_KEY_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sle_pkg::CMD_W-1:0]    command_i,
  input  logic [sle_pkg::PKEY_W-1:0]   key_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sle_pkg::PKEY_W-1:0]   key_out_o,
  output logic [sle_pkg::STATUS_W-1:0] status_o,
  output logic [sle_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                         is_empty_o
);

  import sle_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);

  sle_res_t             res;
  sle_res_t             out_q;
  logic                 out_vld_q;
  logic                 res_take;
  logic                 wr_en;
  logic [AddrW-1:0]     wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;

  sle_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .command_i (command_i),
    .key_in_i  (key_in_i),
    .res_o     (res),
    .res_take_i(res_take),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  sle_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(KEY_WIDTH)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Output register: loads when empty or being drained
  assign res_take = res.valid && (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_take) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign key_out_o     = out_q.key;
  assign status_o      = out_q.status;
  assign entry_count_o = out_q.count;
  assign is_empty_o    = out_q.empty;

endmodule

// ===== src/sle_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_mem
// Key store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sle_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/sle_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sle_ctrl
// Command sequencer: walks the key store one entry per cycle, compares and
// shifts entries by read-modify-write, and builds the result.
// ----------------------------------------------------------------------------
module sle_ctrl #(
  parameter int unsigned CAPACITY  = sle_pkg::SLE_CAPACITY,
  parameter int unsigned KEY_WIDTH = sle_pkg::SLE_KEY_WIDTH,
  localparam int unsigned AddrW = $clog2(CAPACITY)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command side
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sle_pkg::CMD_W-1:0]  command_i,
  input  logic [sle_pkg::PKEY_W-1:0] key_in_i,
  // result side
  output sle_pkg::sle_res_t          res_o,
  input  logic                       res_take_i,
  // key store
  output logic                       wr_en_o,
  output logic [AddrW-1:0]           wr_addr_o,
  output logic [KEY_WIDTH-1:0]       wr_data_o,
  output logic                       rd_en_o,
  output logic [AddrW-1:0]           rd_addr_o,
  input  logic [KEY_WIDTH-1:0]       rd_data_i
);

  import sle_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state_q, state_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [AddrW-1:0]     ptr_q, ptr_d;
  logic [CntW-1:0]      rem_q, rem_d;
  logic                 pend_q, pend_d;
  logic [AddrW-1:0]     pidx_q, pidx_d;
  logic                 hit_q, hit_d;
  logic [KEY_WIDTH-1:0] got_q, got_d;

  logic                 accept;
  logic                 full;
  logic                 done;
  logic [CntW-1:0]      cnt_new;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CntW'(CAPACITY));
  assign done       = (state_q == S_SCAN) && (rem_q == '0) && !pend_q;

  // Next state, store walk and result build
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    key_d     = key_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    hit_d     = hit_q;
    got_d     = got_q;
    wr_en_o   = 1'b0;
    wr_addr_o = '0;
    wr_data_o = key_q;
    rd_en_o   = 1'b0;
    rd_addr_o = ptr_q;
    cnt_new   = cnt_q;
    res_o     = '0;

    // Load a new command
    if (accept) begin
      state_d = S_SCAN;
      cmd_d   = command_i;
      key_d   = KEY_WIDTH'(key_in_i);
      hit_d   = 1'b0;
      ptr_d   = AddrW'(cnt_q - 1'b1);
      rem_d   = cnt_q;
      case (command_i)
        CMD_INSERT: begin
          if (full) begin
            rem_d = '0;
          end
        end
        CMD_RMIN, CMD_RVAL: begin
          ptr_d = '0;
        end
        CMD_RMAX: begin
          rem_d = CntW'(cnt_q != '0);
        end
        default: begin
          rem_d = '0;
        end
      endcase
    end

    if (state_q == S_SCAN) begin
      // Issue the next read; insert walks downward, the others upward
      if (rem_q != '0) begin
        rd_en_o = 1'b1;
        pend_d  = 1'b1;
        pidx_d  = ptr_q;
        rem_d   = rem_q - 1'b1;
        ptr_d   = (cmd_q == CMD_INSERT) ? ptr_q - 1'b1 : ptr_q + 1'b1;
      end

      // Act on the entry read last cycle
      if (pend_q) begin
        case (cmd_q)
          CMD_INSERT: begin
            if (!hit_q) begin
              wr_en_o   = 1'b1;
              wr_addr_o = pidx_q + 1'b1;
              if (rd_data_i >= key_q) begin
                wr_data_o = rd_data_i;
              end else begin
                wr_data_o = key_q;
                hit_d     = 1'b1;
                rem_d     = '0;
              end
            end
          end
          CMD_RMIN: begin
            if (pidx_q == '0) begin
              got_d = rd_data_i;
            end else begin
              wr_en_o   = 1'b1;
              wr_addr_o = pidx_q - 1'b1;
              wr_data_o = rd_data_i;
            end
          end
          CMD_RMAX: begin
            got_d = rd_data_i;
          end
          CMD_RVAL: begin
            if (hit_q) begin
              wr_en_o   = 1'b1;
              wr_addr_o = pidx_q - 1'b1;
              wr_data_o = rd_data_i;
            end else if (rd_data_i == key_q) begin
              hit_d = 1'b1;
            end
          end
          default: begin
            hit_d = hit_q;
          end
        endcase
      end

      // Walk finished: close the command and offer the result
      if (done) begin
        res_o.valid  = 1'b1;
        res_o.key    = PKEY_W'(key_q);
        res_o.status = ST_OK;
        case (cmd_q)
          CMD_INSERT: begin
            if (full) begin
              res_o.status = ST_FULL;
            end else begin
              cnt_new = cnt_q + 1'b1;
              // every stored key was >= the new one: it goes to the head
              if (!hit_q) begin
                wr_en_o   = 1'b1;
                wr_addr_o = '0;
                wr_data_o = key_q;
              end
            end
          end
          CMD_RMIN, CMD_RMAX: begin
            if (cnt_q == '0) begin
              res_o.key    = '0;
              res_o.status = ST_MISS;
            end else begin
              res_o.key = PKEY_W'(got_q);
              cnt_new   = cnt_q - 1'b1;
            end
          end
          CMD_RVAL: begin
            if (hit_q) begin
              cnt_new = cnt_q - 1'b1;
            end else begin
              res_o.status = ST_MISS;
            end
          end
          default: begin
            res_o.status = ST_MISS;
          end
        endcase
        res_o.count = COUNT_W'(cnt_new);
        res_o.empty = (cnt_new == '0);
        if (res_take_i) begin
          cnt_d   = cnt_new;
          state_d = S_IDLE;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      cmd_q   <= CMD_INSERT;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      cmd_q   <= cmd_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    ptr_q  <= ptr_d;
    pidx_q <= pidx_d;
    got_q  <= got_d;
  end

  // Checks
  `SLE_ASSERT(a_cnt_cap, cnt_q <= CntW'(CAPACITY), "stored count above capacity")
  `SLE_ASSERT_IMPL(a_idle_no_wr, state_q == S_IDLE, !wr_en_o, "store written while idle")
  `SLE_ASSERT_IMPL(a_rw_apart, rd_en_o && wr_en_o, rd_addr_o != wr_addr_o,
                   "read and write hit the same entry")
  `SLE_ASSERT_IMPL(a_res_drained, res_o.valid, (rem_q == '0) && !pend_q,
                   "result offered with reads outstanding")
  `SLE_ASSERT_IMPL(a_cnt_on_take, cnt_q != $past(cnt_q), $past(res_take_i),
                   "count changed without a finished item")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_list_engine. Commands go in through the
// valid/stall input channel with random gaps. A shadow copy of the sorted key
// list predicts each reply. Replies are compared field by field, in order,
// while the output channel is stalled at random.
// ----------------------------------------------------------------------------
module testbench;
  import sle_pkg::*;

  localparam int unsigned DEPTH        = SLE_CAPACITY;
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [PKEY_W-1:0]   key;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                empty;
  } reply_t;

  // Shadow list plus the queue of replies still owed by the block
  class sorted_list_board;
    logic [PKEY_W-1:0] held_keys[$];
    reply_t            awaited[$];
    int unsigned       mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Apply one accepted command to the shadow list and queue its reply
    function void note_command(logic [CMD_W-1:0] cmd, logic [PKEY_W-1:0] key);
      reply_t      r;
      int unsigned pos;
      r.key    = key;
      r.status = ST_OK;
      pos      = 0;
      case (cmd)
        CMD_INSERT: begin
          if (held_keys.size() >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // new key goes ahead of any equal keys
            while (pos < held_keys.size() && held_keys[pos] < key) pos++;
            held_keys.insert(pos, key);
          end
        end
        CMD_RMIN, CMD_RMAX: begin
          if (held_keys.size() == 0) begin
            r.key    = '0;
            r.status = ST_MISS;
          end else if (cmd == CMD_RMIN) begin
            r.key = held_keys.pop_front();
          end else begin
            r.key = held_keys.pop_back();
          end
        end
        default: begin
          while (pos < held_keys.size() && held_keys[pos] != key) pos++;
          if (pos >= held_keys.size()) r.status = ST_MISS;
          else held_keys.delete(pos);
        end
      endcase
      r.count = COUNT_W'(held_keys.size());
      r.empty = (held_keys.size() == 0);
      awaited.push_back(r);
    endfunction

    // Compare one reply against the oldest one owed
    function void check_reply(reply_t got);
      reply_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected reply: key %h status %0d count %0d empty %0b",
                   got.key, got.status, got.count, got.empty);
        return;
      end
      want = awaited.pop_front();
      if (got.key !== want.key || got.status !== want.status ||
          got.count !== want.count || got.empty !== want.empty) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: key %h/%h status %0d/%0d count %0d/%0d empty %0b/%0b (exp/got)",
                   want.key, got.key, want.status, got.status,
                   want.count, got.count, want.empty, got.empty);
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i     = CMD_INSERT;
  logic [PKEY_W-1:0]   key_in_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [PKEY_W-1:0]   key_out_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  entry_count_o;
  logic                is_empty_o;

  int unsigned         cycle_count   = 0;
  sorted_list_board    board         = new();

  sorted_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .key_in_i      (key_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .key_out_o     (key_out_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Reply monitor
  always @(posedge clk_i) begin : reply_watch
    reply_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.key    = key_out_o;
      seen.status = status_o;
      seen.count  = entry_count_o;
      seen.empty  = is_empty_o;
      board.check_reply(seen);
    end
  end

  // Output back-pressure: short stalls mostly, a few long ones, some clear runs
  initial begin : stall_gen
    int unsigned r;
    int unsigned len;
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(40, 150);
      end else if (r < 55) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(1, 6);
      end else if (r < 94) begin
        out_stall_i <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        len = $urandom_range(15, 40);
      end
      repeat (len) @(posedge clk_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 45);
  endfunction

  // Keys: small values for duplicates, values near the top, full-range noise
  function automatic logic [PKEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return PKEY_W'($urandom_range(0, 15));
    if (r < 5) return {PKEY_W{1'b1}} - PKEY_W'($urandom_range(0, 3));
    return $urandom();
  endfunction

  // Present one item, wait for acceptance, then record it
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PKEY_W-1:0] key,
                           input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    key_in_i   <= key;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    board.note_command(cmd, key);
  endtask

  // Edge cases: empty removes, single key, duplicates, extremes, full list
  task automatic run_directed();
    send_item(CMD_RMIN, 32'h1234_5678, pick_gap());
    send_item(CMD_RMAX, 32'hFFFF_FFFF, pick_gap());
    send_item(CMD_RVAL, 32'h0000_0000, pick_gap());
    send_item(CMD_INSERT, 32'h0000_0005, pick_gap());
    send_item(CMD_RVAL, 32'h0000_0005, pick_gap());
    send_item(CMD_INSERT, 32'h0000_0000, pick_gap());
    send_item(CMD_INSERT, 32'hFFFF_FFFF, pick_gap());
    send_item(CMD_INSERT, 32'h0000_0007, pick_gap());
    send_item(CMD_INSERT, 32'h0000_0007, pick_gap());
    send_item(CMD_RVAL, 32'h0000_0008, pick_gap());
    send_item(CMD_RVAL, 32'h0000_0007, pick_gap());
    send_item(CMD_RMIN, 32'hA5A5_A5A5, pick_gap());
    send_item(CMD_RMAX, 32'h5A5A_5A5A, pick_gap());
    while (board.held_keys.size() < DEPTH) send_item(CMD_INSERT, $urandom(), pick_gap());
    send_item(CMD_INSERT, 32'h0000_0001, pick_gap());
  endtask

  // Random phases that lean toward filling, draining or a mix
  task automatic run_random();
    int unsigned left;
    int unsigned mode;
    int unsigned span;
    int unsigned quiet;
    int unsigned bias;
    int unsigned gap;
    logic [CMD_W-1:0]  cmd;
    logic [PKEY_W-1:0] key;
    left  = RANDOM_ITEMS;
    span  = 0;
    quiet = 0;
    mode  = 0;
    while (left > 0) begin
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 80);
      end
      bias = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      if ($urandom_range(0, 99) < bias) begin
        cmd = CMD_INSERT;
      end else begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_RMIN;
          1:       cmd = CMD_RMAX;
          default: cmd = CMD_RVAL;
        endcase
      end
      // value removes mostly target a stored key
      if (cmd == CMD_RVAL && board.held_keys.size() > 0 && $urandom_range(0, 9) < 7)
        key = board.held_keys[$urandom_range(0, board.held_keys.size() - 1)];
      else
        key = pick_key();
      if (quiet > 0) begin
        quiet--;
        gap = 0;
      end else if ($urandom_range(0, 99) < 3) begin
        quiet = $urandom_range(20, 60);
        gap   = 0;
      end else begin
        gap = pick_gap();
      end
      send_item(cmd, key, gap);
      left--;
      span--;
    end
  endtask

  // Main sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/sle_pkg.sv
src/sle_mem.sv
src/sle_ctrl.sv
src/sorted_list_engine.sv
verif/testbench.sv
